// ===== sv/swrl_pkg.sv =====
`timescale 1ns / 1ps

package swrl_pkg;

  // Field widths of the transactions.
  localparam int unsigned SIZE_W  = 16;
  localparam int unsigned FRAME_W = 32;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned RATE_W  = 24;
  localparam int unsigned TOTAL_W = 20;
  localparam int unsigned DELAY_W = 26;
  localparam int unsigned CNT_W   = 32;

  // Delay divider: dividend width and iteration counter width.
  localparam int unsigned DIV_W     = 32;
  localparam int unsigned DIV_CNT_W = 6;

  localparam logic [DELAY_W-1:0] MS_PER_SEC = DELAY_W'(1000);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX  = {TOTAL_W{1'b1}};

  // Request codes.
  localparam logic REQ_CHECK  = 1'b0;
  localparam logic REQ_RECORD = 1'b1;

  // Command to the delay divider. The dividend is aligned to the top bit and
  // nbits gives how many quotient bits to produce.
  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     dividend;
    logic [RATE_W-1:0]    divisor;
    logic [DIV_CNT_W-1:0] nbits;
  } div_cmd_t;

  // Status of the delay divider.
  typedef struct packed {
    logic              done;
    logic [DIV_W-1:0]  quotient;
  } div_sts_t;

  // Command to the size window memory.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } win_cmd_t;

endpackage

// ===== sv/swrl_ifs.sv =====
`timescale 1ns / 1ps

// Request channel.
interface swrl_in_if;
  import swrl_pkg::*;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [FRAME_W-1:0] frame_index;
  logic [SIZE_W-1:0]  msg_size;
  logic               spawned;
  logic [TIME_W-1:0]  now_ms;

  modport source (output valid, req_type, frame_index, msg_size, spawned, now_ms,
                  input ready);
  modport sink   (input valid, req_type, frame_index, msg_size, spawned, now_ms,
                  output ready);
endinterface

// Result channel.
interface swrl_out_if;
  import swrl_pkg::*;
  logic               valid;
  logic               ready;
  logic               suppressed;
  logic [TOTAL_W-1:0] window_total;
  logic [TIME_W-1:0]  send_time;
  logic [DELAY_W-1:0] send_delay;
  logic [CNT_W-1:0]   suppress_total;

  modport source (output valid, suppressed, window_total, send_time, send_delay,
                  suppress_total, input ready);
  modport sink   (input valid, suppressed, window_total, send_time, send_delay,
                  suppress_total, output ready);
endinterface

// Configuration write channel.
interface swrl_cfg_if;
  import swrl_pkg::*;
  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] rate_limit;

  modport source (output valid, rate_limit, input ready);
  modport sink   (input valid, rate_limit, output ready);
endinterface

// ===== sv/swrl_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. Done pulses as the last bit
// enters the quotient register; the quotient holds until the next start.
module swrl_div (
  input  logic               clk,
  input  logic               rst_n,
  input  swrl_pkg::div_cmd_t cmd,
  output swrl_pkg::div_sts_t sts
);
  import swrl_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]     dvd_r;
  logic [RATE_W-1:0]    dsr_r;
  logic [RATE_W-1:0]    rem_r;
  logic [RATE_W:0]      trial;
  logic [RATE_W:0]      diff;
  logic                 qbit;

  // Trial subtraction of the divisor from the shifted partial remainder.
  always_comb begin
    trial = {rem_r, dvd_r[DIV_W-1]};
    diff  = trial - {1'b0, dsr_r};
    qbit  = (trial >= {1'b0, dsr_r});
  end

  // Control: iteration count, busy and done.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= cmd.nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend register shifts left and takes quotient bits in.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dvd_r <= cmd.dividend;
      dsr_r <= cmd.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DIV_W-2:0], qbit};
      rem_r <= qbit ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
    end
  end

  assign sts.done     = done_r;
  assign sts.quotient = dvd_r;

endmodule

// ===== sv/swrl_win.sv =====
`timescale 1ns / 1ps

// Size window: one-port synchronous memory with valid bits and the running
// sum of all slots. A write replaces the entry read in the previous access.
module swrl_win #(
  parameter int unsigned WINDOW = 16,
  parameter int unsigned AW     = 4,
  parameter int unsigned SUM_W  = 20
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  swrl_pkg::win_cmd_t        cmd,
  input  logic [AW-1:0]             addr,
  input  logic [swrl_pkg::SIZE_W-1:0] wr_data,
  output logic [SUM_W-1:0]          sum
);
  import swrl_pkg::*;

  logic [SIZE_W-1:0] mem [WINDOW];
  logic [WINDOW-1:0] valid_r;
  logic [SIZE_W-1:0] rdata_r;
  logic              rvalid_r;
  logic [SUM_W-1:0]  sum_r;
  logic [SIZE_W-1:0] old_val;

  // Memory array and its registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  // Valid bits: an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (cmd.wr_en) begin
        valid_r[addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rvalid_r <= valid_r[addr];
      end
    end
  end

  assign old_val = rvalid_r ? rdata_r : '0;

  // Running sum follows every slot write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (cmd.wr_en) begin
      sum_r <= sum_r - SUM_W'(old_val) + SUM_W'(wr_data);
    end
  end

  assign sum = sum_r;

endmodule

// ===== sv/sliding_window_rate_limiter.sv =====
`timescale 1ns / 1ps
// Sequence: a check or an unlimited record passes from acceptance through the read
// and update states to a valid result; a record with a nonzero rate also waits in
// the divide state (26-bit delay divider). A WINDOW that is not a power of two adds
// the slot-remainder state before the read. One transaction at a time; a result
// waiting on out_if.ready holds the next one in its update state.
// Reset: synchronous active-low rst_n clears the window, sum, counters and rate.
module sliding_window_rate_limiter #(
  parameter int unsigned WINDOW       = 16,
  parameter int unsigned RATE_DIVISOR = 1
) (
  input logic           clk,
  input logic           rst_n,
  swrl_in_if.sink       in_if,
  swrl_out_if.source    out_if,
  swrl_cfg_if.sink      cfg_if
);
  import swrl_pkg::*;

  localparam int unsigned AW       = $clog2(WINDOW);
  localparam int unsigned SUM_W    = SIZE_W + $clog2(WINDOW);
  localparam bit          WIN_POW2 = ((WINDOW & (WINDOW - 1)) == 0);

  // Slot remainder for other window sizes: the frame number is folded with
  // 2^16 mod WINDOW, then divided by reciprocal multiplication.
  localparam int unsigned HALF_W  = FRAME_W / 2;
  localparam int unsigned FOLD_W  = HALF_W + AW + 1;
  localparam int unsigned MOD_S   = FOLD_W + AW;
  localparam int unsigned MOD_P_W = 2 * FOLD_W + 2;
  localparam logic [AW-1:0]     FOLD_C = AW'((64'd1 << HALF_W) % 64'(WINDOW));
  localparam logic [FOLD_W+1:0] MOD_M  =
    (FOLD_W + 2)'(((64'd1 << MOD_S) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  // Window quotient by reciprocal multiplication with the fixed divisor.
  localparam int unsigned QUO_L   = $clog2(RATE_DIVISOR);
  localparam int unsigned QUO_S   = SUM_W + QUO_L;
  localparam int unsigned QUO_P_W = QUO_S + SUM_W + 2;
  localparam logic [SUM_W+1:0] QUO_M =
    (SUM_W + 2)'(((64'd1 << QUO_S) + 64'(RATE_DIVISOR) - 64'd1) / 64'(RATE_DIVISOR));

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MOD  = 6'b000010,
    S_READ = 6'b000100,
    S_DIV  = 6'b001000,
    S_UPD  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  logic [RATE_W-1:0]  rate_r;
  logic               req_r;
  logic [SIZE_W-1:0]  size_r;
  logic               spawned_r;
  logic [TIME_W-1:0]  now_r;
  logic [DELAY_W-1:0] prod_r;
  logic [FOLD_W-1:0]  fold_r;
  logic [AW-1:0]      slot_r;
  logic [DIV_W-1:0]   quo_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [TIME_W-1:0]  last_time_r;
  logic [DELAY_W-1:0] last_delay_r;

  logic               out_valid_r;
  logic               o_supp_r;
  logic [TOTAL_W-1:0] o_total_r;
  logic [TIME_W-1:0]  o_time_r;
  logic [DELAY_W-1:0] o_delay_r;
  logic [CNT_W-1:0]   o_cnt_r;

  div_cmd_t           div_cmd;
  div_sts_t           div_sts;
  win_cmd_t           win_cmd;
  logic [SUM_W-1:0]   sum;
  logic [SIZE_W-1:0]  wr_data;

  logic               in_fire;
  logic               upd_fire;
  logic               rate_on;
  logic               over;
  logic [TOTAL_W-1:0] total;
  logic [CNT_W-1:0]   cnt_nxt;
  logic [MOD_P_W-1:0] mod_prod;
  logic [AW-1:0]      mod_q;
  logic [QUO_P_W-1:0] quo_prod;

  assign rate_on  = (rate_r != '0);
  assign in_fire  = in_if.valid && in_if.ready;
  assign in_if.ready = (state_r == S_IDLE);
  assign upd_fire = (state_r == S_UPD) && (!out_valid_r || out_if.ready);

  // Configuration register; writes must arrive only while idle, which the block does not enforce.
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= '0;
    end else if (cfg_if.valid) begin
      rate_r <= cfg_if.rate_limit;
    end
  end

  // Request capture; the delay numerator and the folded frame are formed on acceptance.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r     <= in_if.req_type;
      size_r    <= in_if.msg_size;
      spawned_r <= in_if.spawned;
      now_r     <= in_if.now_ms;
      prod_r    <= DELAY_W'(in_if.msg_size) * MS_PER_SEC;
      fold_r    <= FOLD_W'(in_if.frame_index[FRAME_W-1:HALF_W]) * FOLD_W'(FOLD_C) +
                   FOLD_W'(in_if.frame_index[HALF_W-1:0]);
    end
  end

  // Reciprocal products for the slot remainder and the window quotient.
  always_comb begin
    mod_prod = MOD_P_W'(fold_r) * MOD_P_W'(MOD_M);
    mod_q    = mod_prod[MOD_S +: AW];
    quo_prod = QUO_P_W'(sum) * QUO_P_W'(QUO_M);
  end

  // Slot index: low bits for a power-of-two window, else the folded remainder.
  always_ff @(posedge clk) begin
    if (in_fire && WIN_POW2) begin
      slot_r <= in_if.frame_index[AW-1:0];
    end else if (state_r == S_MOD) begin
      slot_r <= fold_r[AW-1:0] - AW'(mod_q * WINDOW);
    end
  end

  // Window quotient, taken while the slot is being read.
  always_ff @(posedge clk) begin
    if ((state_r == S_READ) && (req_r == REQ_CHECK)) begin
      quo_r <= DIV_W'(quo_prod[QUO_S +: SUM_W]);
    end
  end

  // Divider request for the send delay of a record with a nonzero rate.
  always_comb begin
    div_cmd = '0;
    if ((state_r == S_READ) && (req_r == REQ_RECORD) && rate_on) begin
      div_cmd.start    = 1'b1;
      div_cmd.dividend = {prod_r, {(DIV_W - DELAY_W){1'b0}}};
      div_cmd.divisor  = rate_r;
      div_cmd.nbits    = DIV_CNT_W'(DELAY_W);
    end
  end

  swrl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (div_cmd),
    .sts   (div_sts)
  );

  // Over-budget test and slot update for the transaction being finished.
  always_comb begin
    over = (req_r == REQ_CHECK) && rate_on &&
           (quo_r > DIV_W'(rate_r));
    total = (quo_r > DIV_W'(TOTAL_MAX)) ? TOTAL_MAX : quo_r[TOTAL_W-1:0];
    cnt_nxt = cnt_r + CNT_W'(over);
    wr_data = (req_r == REQ_RECORD) ? size_r : '0;
    win_cmd.rd_en = (state_r == S_READ);
    win_cmd.wr_en = upd_fire &&
                    (over || ((req_r == REQ_RECORD) && rate_on && spawned_r));
  end

  swrl_win #(
    .WINDOW (WINDOW),
    .AW     (AW),
    .SUM_W  (SUM_W)
  ) u_win (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (win_cmd),
    .addr    (slot_r),
    .wr_data (wr_data),
    .sum     (sum)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = WIN_POW2 ? S_READ : S_MOD;
        end
      end
      S_MOD: begin
        state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = ((req_r == REQ_RECORD) && rate_on) ? S_DIV : S_UPD;
      end
      S_DIV: begin
        if (div_sts.done) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (upd_fire) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Counters and last-send state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      last_time_r  <= '0;
      last_delay_r <= '0;
    end else if (upd_fire) begin
      cnt_r <= cnt_nxt;
      if (req_r == REQ_RECORD) begin
        last_time_r  <= now_r;
        last_delay_r <= rate_on ? div_sts.quotient[DELAY_W-1:0] : '0;
      end
    end
  end

  // Result register; the next request is taken while a result waits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (upd_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      o_cnt_r <= cnt_nxt;
      if (req_r == REQ_CHECK) begin
        o_supp_r  <= over;
        o_total_r <= total;
        o_time_r  <= last_time_r;
        o_delay_r <= last_delay_r;
      end else begin
        o_supp_r  <= 1'b0;
        o_total_r <= '0;
        o_time_r  <= now_r;
        o_delay_r <= rate_on ? div_sts.quotient[DELAY_W-1:0] : '0;
      end
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.suppressed     = o_supp_r;
  assign out_if.window_total   = o_total_r;
  assign out_if.send_time      = o_time_r;
  assign out_if.send_delay     = o_delay_r;
  assign out_if.suppress_total = o_cnt_r;

endmodule
